// File: src/sbe_pkg.sv
package sbe_pkg;

  localparam int unsigned StackDepth   = 256;
  localparam int unsigned CallDepth    = 32;
  localparam int unsigned CodeAddrBits = 16;
  localparam int unsigned SpBits       = $clog2(StackDepth + 1);
  localparam int unsigned SaBits       = $clog2(StackDepth);
  localparam int unsigned CdBits       = $clog2(CallDepth + 1);
  localparam int unsigned CaBits       = (CallDepth > 1) ? $clog2(CallDepth) : 1;

  typedef logic [SpBits-1:0]       sp_t;
  typedef logic [SaBits-1:0]       saddr_t;
  typedef logic [CdBits-1:0]       cd_t;
  typedef logic [CodeAddrBits-1:0] pc_t;

  typedef enum logic [4:0] {
    OpNeg = 5'd0, OpNot = 5'd1, OpAdd = 5'd2, OpSub = 5'd3, OpMul = 5'd4,
    OpDiv = 5'd5, OpEq = 5'd6, OpNeq = 5'd7, OpLt = 5'd8, OpLte = 5'd9,
    OpGt = 5'd10, OpGte = 5'd11, OpAnd = 5'd12, OpOr = 5'd13, OpLoad = 5'd14,
    OpStore = 5'd15, OpInt = 5'd16, OpTrue = 5'd17, OpFalse = 5'd18,
    OpJmp = 5'd19, OpJmpIf = 5'd20, OpStkAdj = 5'd21, OpCall = 5'd22,
    OpRet = 5'd23
  } opcode_e;

  localparam logic [2:0] FaultNone      = 3'd0;
  localparam logic [2:0] FaultOverflow  = 3'd1;
  localparam logic [2:0] FaultUnderflow = 3'd2;
  localparam logic [2:0] FaultDivZero   = 3'd3;
  localparam logic [2:0] FaultCallDepth = 3'd4;

  // Request to the shared arithmetic unit.
  typedef struct packed {
    logic        start;
    logic [4:0]  op;
    logic [31:0] x;
    logic [31:0] y;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage

// File: src/sbe_alu.sv
module sbe_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbe_pkg::alu_req_t req_i,
  output sbe_pkg::alu_rsp_t rsp_o
);
  import sbe_pkg::*;

  typedef enum logic [3:0] {
    AIdle = 4'b0001, AMul = 4'b0010, ADiv = 4'b0100, ADone = 4'b1000
  } alu_state_e;

  alu_state_e  state_q, state_d;
  logic [31:0] res_q, res_d;
  logic [31:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] trial;
  logic [31:0] ax, ay;

  assign ax = req_i.x[31] ? (32'd0 - req_i.x) : req_i.x;
  assign ay = req_i.y[31] ? (32'd0 - req_i.y) : req_i.y;
  assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    res_d = res_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    unique case (state_q)
      AIdle: begin
        if (req_i.start) begin
          state_d = ADone;
          case (req_i.op)
            OpAdd: res_d = req_i.x + req_i.y;
            OpSub: res_d = req_i.x - req_i.y;
            OpMul: begin
              state_d = AMul;
            end
            OpDiv: begin
              if (req_i.y == 32'd0) begin
                res_d = 32'd0;
              end else begin
                quo_d = ax;
                rem_d = 33'd0;
                dvs_d = ay;
                neg_d = req_i.x[31] ^ req_i.y[31];
                cnt_d = 5'd0;
                state_d = ADiv;
              end
            end
            OpEq:  res_d = {31'd0, req_i.x == req_i.y};
            OpNeq: res_d = {31'd0, req_i.x != req_i.y};
            OpLt:  res_d = {31'd0, $signed(req_i.x) < $signed(req_i.y)};
            OpLte: res_d = {31'd0, $signed(req_i.x) <= $signed(req_i.y)};
            OpGt:  res_d = {31'd0, $signed(req_i.x) > $signed(req_i.y)};
            OpGte: res_d = {31'd0, $signed(req_i.x) >= $signed(req_i.y)};
            OpAnd: res_d = {31'd0, (req_i.x != 32'd0) && (req_i.y != 32'd0)};
            default: res_d = {31'd0, (req_i.x != 32'd0) || (req_i.y != 32'd0)};
          endcase
          dvs_d = (req_i.op == OpMul) ? req_i.y : dvs_d;
          quo_d = (req_i.op == OpMul) ? req_i.x : quo_d;
        end
      end
      AMul: begin
        res_d = quo_q * dvs_q;
        state_d = ADone;
      end
      ADiv: begin
        if (!trial[32]) begin
          rem_d = trial;
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = {rem_q[31:0], quo_q[31]};
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          res_d = neg_q ? (32'd0 - quo_d) : quo_d;
          state_d = ADone;
        end
      end
      ADone: state_d = AIdle;
      default: state_d = AIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
  end

  assign rsp_o.done   = (state_q == ADone);
  assign rsp_o.result = res_q;

endmodule

// File: src/stack_bytecode_executor.sv
// Stack bytecode executor.
// The input channel (in_valid_i/in_ready_o) moves one instruction per
// transaction: opcode_i, operand_a_i and operand_b_i. The output channel
// (out_valid_o/out_ready_i) moves one result transaction per instruction:
// next_pc_o, top_value_o, done_res_o and fault_o.
// One instruction occupies the block from acceptance until its result is
// taken; in_ready_o is low meanwhile and rises again in the cycle after the
// result is taken. Unary, push, store, jump, stack-adjust, call, unassigned
// and nested return instructions pass from acceptance to the result through
// operand stack read, execute or write-back, top-of-stack read, top capture
// and result. The operand stack memory has one read port, so binary ops add
// a second read and, unless they underflow, a pass through the shared ALU;
// mul adds a multiply step and div the restoring divider in the shared unit.
// A zero divisor skips it; the outermost return skips top read and capture.
// Reset clears the pc to entry_pc (0), the stack pointer and the call depth.
// The operand stack and call stacks need no clearing. Writing entry_pc with
// cfg_we_i also loads the pc. If the receiver stalls, the result is held
// and no new instruction is taken until it is accepted.
module stack_bytecode_executor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  opcode_i,
  input  logic [31:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] next_pc_o,
  output logic [31:0] top_value_o,
  output logic        done_res_o,
  output logic [2:0]  fault_o
);
  import sbe_pkg::*;

  typedef enum logic [7:0] {
    SIdle = 8'b00000001, SRd1 = 8'b00000010, SRd2 = 8'b00000100,
    SExec = 8'b00001000, SAlu = 8'b00010000, STop = 8'b00100000,
    STopW = 8'b01000000, SOut = 8'b10000000
  } state_e;

  state_e      state_q;
  logic [15:0] entry_q;
  pc_t         pc_q;
  sp_t         sp_q;
  cd_t         cd_q;
  logic [4:0]  op_q;
  logic [31:0] a_q;
  logic [15:0] b_q;
  logic [31:0] x_q, y_q;
  pc_t         npc_q;
  logic [31:0] top_q;
  logic        done_q;
  logic [2:0]  fault_q;

  logic [31:0] stk_mem [StackDepth];
  pc_t         rpc_mem [CallDepth];
  sp_t         fb_mem  [CallDepth];
  logic [31:0] rd_q;
  pc_t         rpc_rd_q;
  sp_t         fb_rd_q;

  // Memory port controls, chosen by the sequencer.
  logic        mre;
  saddr_t      mra;
  logic        mwe;
  saddr_t      mwa;
  logic [31:0] mwd;
  logic        cwe;
  logic        cre;

  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;

  sbe_alu u_alu (.clk_i, .rst_ni, .req_i(alu_req), .rsp_o(alu_rsp));

  logic        is_unary, is_binary, is_push;
  logic [32:0] sp_ext, ns;
  sp_t         fb_call, fb_ret;
  logic [31:0] push_v;

  assign is_unary  = (op_q == OpNeg) || (op_q == OpNot);
  assign is_binary = (op_q >= OpAdd) && (op_q <= OpOr);
  assign is_push   = (op_q == OpLoad) || (op_q == OpInt) || (op_q == OpTrue) ||
                     (op_q == OpFalse);
  assign push_v    = (op_q == OpTrue) ? 32'd1 : (op_q == OpFalse) ? 32'd0 : a_q;
  assign sp_ext    = {{(33-SpBits){1'b0}}, sp_q};
  assign ns        = sp_ext + a_q;
  assign fb_call   = sp_q - a_q[SpBits-1:0];
  assign fb_ret    = (fb_rd_q >= sp_t'(StackDepth)) ? sp_t'(StackDepth - 1) : fb_rd_q;

  always_ff @(posedge clk_i) begin
    if (mre) rd_q <= stk_mem[mra];
    if (mwe) stk_mem[mwa] <= mwd;
  end

  // The return address is the word after the three-word call instruction.
  always_ff @(posedge clk_i) begin
    if (cwe) begin
      rpc_mem[cd_q[CaBits-1:0]] <= pc_q + pc_t'(3);
      fb_mem[cd_q[CaBits-1:0]]  <= fb_call;
    end
    if (cre) begin
      rpc_rd_q <= rpc_mem[CaBits'(cd_q - cd_t'(1))];
      fb_rd_q  <= fb_mem[CaBits'(cd_q - cd_t'(1))];
    end
  end

  always_comb begin
    mre = 1'b0;
    mra = saddr_t'(sp_q - sp_t'(1));
    mwe = 1'b0;
    mwa = saddr_t'(sp_q - sp_t'(1));
    mwd = alu_rsp.result;
    cwe = 1'b0;
    cre = 1'b0;
    alu_req = '{start: 1'b0, op: op_q, x: x_q, y: y_q};
    unique case (state_q)
      SIdle: ;
      SRd1: begin
        mre = (sp_q != '0);
        cre = (op_q == OpRet) && (cd_q != '0);
      end
      SRd2: begin
        mre = 1'b1;
        mra = saddr_t'(sp_q - sp_t'(2));
      end
      SExec: begin
        if (is_binary && sp_q >= sp_t'(2)) begin
          alu_req.start = 1'b1;
          alu_req.x = rd_q;
        end
        if (op_q == OpNeg && sp_q != '0) begin
          mwe = 1'b1;
          mwd = 32'd0 - rd_q;
        end
        if (op_q == OpNot && sp_q != '0) begin
          mwe = 1'b1;
          mwd = {31'd0, rd_q == 32'd0};
        end
        if (is_push && sp_q < sp_t'(StackDepth)) begin
          mwe = 1'b1;
          mwa = saddr_t'(sp_q);
          mwd = push_v;
        end
        if (op_q == OpCall && cd_q < cd_t'(CallDepth) && !a_q[31] &&
            a_q <= sp_ext[31:0] && fb_call < sp_t'(StackDepth)) begin
          cwe = 1'b1;
        end
        if (op_q == OpRet && cd_q != '0) begin
          mwe = 1'b1;
          mwa = saddr_t'(fb_ret);
          mwd = (sp_q != '0) ? rd_q : 32'd0;
        end
      end
      SAlu: begin
        if (alu_rsp.done) begin
          mwe = 1'b1;
          mwa = saddr_t'(sp_q - sp_t'(2));
        end
      end
      STop: mre = (sp_q != '0);
      STopW: ;
      SOut: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      entry_q <= '0;
      pc_q    <= '0;
      sp_q    <= '0;
      cd_q    <= '0;
      npc_q   <= '0;
      top_q   <= '0;
      done_q  <= 1'b0;
      fault_q <= FaultNone;
    end else begin
      if (cfg_we_i) begin
        entry_q <= cfg_wdata_i;
        pc_q    <= pc_t'(cfg_wdata_i);
      end
      unique case (state_q)
        SIdle: if (in_valid_i) begin
          npc_q   <= pc_q + pc_t'(1);
          done_q  <= 1'b0;
          fault_q <= FaultNone;
          state_q <= SRd1;
        end
        SRd1: state_q <= is_binary ? SRd2 : SExec;
        SRd2: state_q <= SExec;
        SExec: begin
          state_q <= STop;
          if (is_unary) begin
            if (sp_q == '0) fault_q <= FaultUnderflow;
          end else if (is_binary) begin
            if (sp_q < sp_t'(2)) fault_q <= FaultUnderflow;
            else begin
              state_q <= SAlu;
              if (op_q == OpDiv && y_q == 32'd0) fault_q <= FaultDivZero;
            end
          end else if (is_push) begin
            if (op_q == OpLoad || op_q == OpInt) npc_q <= pc_q + pc_t'(2);
            if (sp_q >= sp_t'(StackDepth)) fault_q <= FaultOverflow;
            else sp_q <= sp_q + sp_t'(1);
          end else if (op_q == OpStore) begin
            if (sp_q == '0) fault_q <= FaultUnderflow;
            else sp_q <= sp_q - sp_t'(1);
          end else if (op_q == OpJmp) begin
            npc_q <= pc_q + pc_t'(1) + a_q[CodeAddrBits-1:0];
          end else if (op_q == OpJmpIf) begin
            npc_q <= pc_q + pc_t'(2);
            if (sp_q == '0) fault_q <= FaultUnderflow;
            else begin
              sp_q <= sp_q - sp_t'(1);
              if (rd_q == 32'd0) npc_q <= pc_q + pc_t'(1) + a_q[CodeAddrBits-1:0];
            end
          end else if (op_q == OpStkAdj) begin
            npc_q <= pc_q + pc_t'(2);
            if (ns[32] ^ a_q[31]) fault_q <= FaultUnderflow;
            else if (ns[31:0] > 32'(StackDepth)) fault_q <= FaultOverflow;
            else sp_q <= ns[SpBits-1:0];
          end else if (op_q == OpCall) begin
            npc_q <= pc_q + pc_t'(3);
            if (cd_q >= cd_t'(CallDepth)) fault_q <= FaultCallDepth;
            else if (a_q[31] || a_q > sp_ext[31:0]) fault_q <= FaultUnderflow;
            else if (fb_call >= sp_t'(StackDepth)) fault_q <= FaultOverflow;
            else begin
              cd_q  <= cd_q + cd_t'(1);
              sp_q  <= fb_call;
              npc_q <= pc_t'(b_q);
            end
          end else if (op_q == OpRet) begin
            top_q <= (sp_q != '0) ? rd_q : 32'd0;
            if (sp_q == '0) fault_q <= FaultUnderflow;
            if (cd_q == '0) begin
              done_q  <= 1'b1;
              sp_q    <= '0;
              npc_q   <= pc_t'(entry_q);
              state_q <= SOut;
            end else begin
              cd_q  <= cd_q - cd_t'(1);
              sp_q  <= fb_ret + sp_t'(1);
              npc_q <= rpc_rd_q;
            end
          end
        end
        SAlu: if (alu_rsp.done) begin
          sp_q    <= sp_q - sp_t'(1);
          state_q <= STop;
        end
        STop: state_q <= STopW;
        STopW: begin
          top_q   <= (sp_q != '0) ? rd_q : 32'd0;
          pc_q    <= npc_q;
          state_q <= SOut;
        end
        SOut: begin
          if (done_q) pc_q <= npc_q;
          if (out_ready_i) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // Payload capture registers; no reset needed.
  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i) begin
      op_q <= opcode_i;
      a_q  <= operand_a_i;
      b_q  <= operand_b_i;
    end
    if (state_q == SRd2) y_q <= rd_q;
    if (state_q == SExec) x_q <= rd_q;
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign next_pc_o   = 16'(npc_q);
  assign top_value_o = top_q;
  assign done_res_o  = done_q;
  assign fault_o     = fault_q;

  // The stack pointer never passes the stack depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= sp_t'(StackDepth))
    else $error("stack pointer beyond depth");

  // The call depth never passes its bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cd_q <= cd_t'(CallDepth))
    else $error("call depth beyond bound");

  // A held result stays put while the receiver stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(top_value_o))
    else $error("result changed under stall");

  // The block never accepts an item while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted with pending result");

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sbe_pkg::*;

  // Opcodes 24..31 are unassigned and must behave as one-word no-ops.
  localparam logic [4:0] OpUnusedLo = 5'd24;
  localparam logic [4:0] OpUnusedHi = 5'd31;
  localparam int unsigned RandPerPhase = 600;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic [4:0]  op;
    logic [31:0] a;
    logic [15:0] b;
  } instr_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [31:0] top;
    logic        done;
    logic [2:0]  fault;
  } outcome_t;

  // One row of the directed table: an instruction and, where it is obvious,
  // the outcome typed in by hand. Rows with chk low use the predictor.
  typedef struct packed {
    logic [4:0]  op;
    logic [31:0] a;
    logic [15:0] b;
    logic        chk;
    outcome_t    want;
  } dir_row_t;

  localparam int unsigned DirRows = 28;
  localparam dir_row_t DirTable [DirRows] = '{
    // Return on an empty stack right after reset: completes with value 0.
    '{OpRet,    32'd0,          16'd0,     1'b1, '{16'd0, 32'd0, 1'b1, FaultUnderflow}},
    '{OpNeg,    32'd0,          16'd0,     1'b1, '{16'd1, 32'd0, 1'b0, FaultUnderflow}},
    '{OpInt,    32'h8000_0000,  16'd0,     1'b1, '{16'd3, 32'h8000_0000, 1'b0, FaultNone}},
    '{OpInt,    32'hFFFF_FFFF,  16'd0,     1'b1, '{16'd5, 32'hFFFF_FFFF, 1'b0, FaultNone}},
    // The most negative value divided by minus one wraps back to itself.
    '{OpDiv,    32'd0,          16'd0,     1'b0, '0},
    '{OpInt,    32'd0,          16'd0,     1'b0, '0},
    '{OpDiv,    32'd0,          16'd0,     1'b1, '{16'd9, 32'd0, 1'b0, FaultDivZero}},
    '{OpNeg,    32'd0,          16'd0,     1'b0, '0},
    '{OpNot,    32'd0,          16'd0,     1'b0, '0},
    '{OpLoad,   32'h7FFF_FFFF,  16'hFFFF,  1'b0, '0},
    '{OpAdd,    32'd0,          16'd0,     1'b0, '0},
    '{OpInt,    32'd3,          16'd0,     1'b0, '0},
    '{OpMul,    32'd0,          16'd0,     1'b0, '0},
    '{OpTrue,   32'd0,          16'd0,     1'b0, '0},
    '{OpSub,    32'd0,          16'd0,     1'b0, '0},
    '{OpLt,     32'd0,          16'd0,     1'b0, '0},
    '{OpFalse,  32'd0,          16'd0,     1'b0, '0},
    '{OpOr,     32'd0,          16'd0,     1'b0, '0},
    '{OpStore,  32'd0,          16'd0,     1'b0, '0},
    '{OpJmp,    32'hFFFF_FFFD,  16'd0,     1'b0, '0},
    '{OpJmpIf,  32'd5,          16'd0,     1'b0, '0},
    '{OpStkAdj, 32'hFFFF_FFFF,  16'd0,     1'b0, '0},
    '{OpStkAdj, 32'd300,        16'd0,     1'b0, '0},
    '{OpInt,    32'd9,          16'd0,     1'b0, '0},
    '{OpCall,   32'd1,          16'hFFFF,  1'b0, '0},
    '{OpRet,    32'd0,          16'd0,     1'b0, '0},
    '{OpUnusedHi, 32'd0,        16'd0,     1'b0, '0},
    '{OpRet,    32'd0,          16'd0,     1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [4:0]  opcode_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [15:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] next_pc_o;
  logic [31:0] top_value_o;
  logic        done_res_o;
  logic [2:0]  fault_o;

  stack_bytecode_executor uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .opcode_i, .operand_a_i, .operand_b_i,
    .out_valid_o, .out_ready_i, .next_pc_o, .top_value_o, .done_res_o, .fault_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the machine state kept by the predictor.
  logic [15:0] entry_q = '0;
  logic [15:0] pc_q = '0;
  logic [31:0] stk [StackDepth];
  bit          wr [StackDepth];
  int          sp_q = 0;
  logic [15:0] ret_pc [CallDepth];
  int          frame [CallDepth];
  int          depth_q = 0;

  outcome_t    pending_q [$];
  instr_t      plan_q [$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_req = 1'b0;

  // Executes one instruction on the shadow state and returns its outcome.
  task automatic execute(input instr_t it, output outcome_t r);
    logic [31:0] x, y, v, rv;
    logic [15:0] nx;
    logic [2:0]  f;
    logic        dn;
    longint      ns, sa;
    int          fb;
    nx = pc_q + 16'd1;
    f = FaultNone;
    dn = 1'b0;
    rv = '0;
    sa = longint'($signed(it.a));
    if (it.op == OpNeg || it.op == OpNot) begin
      if (sp_q < 1) f = FaultUnderflow;
      else if (it.op == OpNeg) stk[sp_q-1] = -stk[sp_q-1];
      else stk[sp_q-1] = {31'd0, stk[sp_q-1] == 32'd0};
    end else if (it.op >= OpAdd && it.op <= OpOr) begin
      if (sp_q < 2) f = FaultUnderflow;
      else begin
        x = stk[sp_q-2];
        y = stk[sp_q-1];
        case (it.op)
          OpAdd: v = x + y;
          OpSub: v = x - y;
          OpMul: v = x * y;
          OpDiv: begin
            if (y == 32'd0) begin
              f = FaultDivZero;
              v = '0;
            end else if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) v = x;
            else v = 32'($signed(x) / $signed(y));
          end
          OpEq:  v = {31'd0, x == y};
          OpNeq: v = {31'd0, x != y};
          OpLt:  v = {31'd0, $signed(x) < $signed(y)};
          OpLte: v = {31'd0, $signed(x) <= $signed(y)};
          OpGt:  v = {31'd0, $signed(x) > $signed(y)};
          OpGte: v = {31'd0, $signed(x) >= $signed(y)};
          OpAnd: v = {31'd0, (x != 0) && (y != 0)};
          default: v = {31'd0, (x != 0) || (y != 0)};
        endcase
        stk[sp_q-2] = v;
        sp_q--;
      end
    end else if (it.op == OpLoad || it.op == OpInt || it.op == OpTrue ||
                 it.op == OpFalse) begin
      v = (it.op == OpTrue) ? 32'd1 : (it.op == OpFalse) ? 32'd0 : it.a;
      if (it.op == OpLoad || it.op == OpInt) nx = pc_q + 16'd2;
      if (sp_q >= StackDepth) f = FaultOverflow;
      else begin
        stk[sp_q] = v;
        wr[sp_q] = 1'b1;
        sp_q++;
      end
    end else if (it.op == OpStore) begin
      if (sp_q < 1) f = FaultUnderflow;
      else sp_q--;
    end else if (it.op == OpJmp) begin
      nx = pc_q + 16'd1 + it.a[15:0];
    end else if (it.op == OpJmpIf) begin
      nx = pc_q + 16'd2;
      if (sp_q < 1) f = FaultUnderflow;
      else begin
        sp_q--;
        if (stk[sp_q] == 32'd0) nx = pc_q + 16'd1 + it.a[15:0];
      end
    end else if (it.op == OpStkAdj) begin
      ns = sp_q + sa;
      nx = pc_q + 16'd2;
      if (ns < 0) f = FaultUnderflow;
      else if (ns > StackDepth) f = FaultOverflow;
      else sp_q = int'(ns);
    end else if (it.op == OpCall) begin
      nx = pc_q + 16'd3;
      if (depth_q >= CallDepth) f = FaultCallDepth;
      else if (sa < 0 || sa > sp_q) f = FaultUnderflow;
      else if (sp_q - sa >= StackDepth) f = FaultOverflow;
      else begin
        fb = sp_q - int'(sa);
        ret_pc[depth_q] = nx;
        frame[depth_q] = fb;
        depth_q++;
        sp_q = fb;
        nx = it.b;
      end
    end else if (it.op == OpRet) begin
      if (sp_q < 1) f = FaultUnderflow;
      else rv = stk[sp_q-1];
      if (depth_q == 0) begin
        dn = 1'b1;
        sp_q = 0;
        nx = entry_q;
      end else begin
        depth_q--;
        fb = frame[depth_q];
        if (fb >= StackDepth) fb = StackDepth - 1;
        stk[fb] = rv;
        wr[fb] = 1'b1;
        sp_q = fb + 1;
        nx = ret_pc[depth_q];
      end
    end
    pc_q = nx;
    r.pc = nx;
    r.top = dn ? rv : (sp_q > 0) ? stk[sp_q-1] : 32'd0;
    r.done = dn;
    r.fault = f;
  endtask

  // True when the instruction would not read a stack entry that was never
  // written. The entry under the top is always written, so only the entries
  // that the instruction newly exposes need a look.
  function automatic bit reads_written(input instr_t it);
    longint sa, ns;
    int fb;
    sa = longint'($signed(it.a));
    if (it.op == OpNeg || it.op == OpNot) return sp_q == 0 || wr[sp_q-1];
    if (it.op >= OpAdd && it.op <= OpOr)
      return sp_q < 2 ? (sp_q == 0 || wr[sp_q-1]) : (wr[sp_q-1] && wr[sp_q-2]);
    if (it.op == OpStore) return sp_q <= 1 || wr[sp_q-2];
    if (it.op == OpJmpIf) return sp_q == 0 || (wr[sp_q-1] && (sp_q == 1 || wr[sp_q-2]));
    if (it.op == OpStkAdj) begin
      ns = sp_q + sa;
      if (ns < 0 || ns > StackDepth) return 1'b1;
      return ns == 0 || wr[int'(ns)-1];
    end
    if (it.op == OpCall) begin
      if (depth_q >= CallDepth || sa < 0 || sa > sp_q || sp_q - sa >= StackDepth)
        return 1'b1;
      fb = sp_q - int'(sa);
      return fb == 0 || wr[fb-1];
    end
    if (it.op == OpRet) return sp_q == 0 || wr[sp_q-1];
    return 1'b1;
  endfunction

  // Random instruction with a bias toward short operands, so that the stack
  // and the call stack stay in their interesting range.
  function automatic instr_t pick_instr();
    instr_t it;
    int roll;
    roll = $urandom_range(0, 99);
    it.b = 16'($urandom);
    it.a = $urandom;
    if (roll < 3) it.op = 5'($urandom_range(OpUnusedLo, OpUnusedHi));
    else if (roll < 30) it.op = 5'($urandom_range(OpAdd, OpOr));
    else if (roll < 50) it.op = ($urandom_range(0, 1) == 0) ? OpInt : OpLoad;
    else it.op = 5'($urandom_range(OpNeg, OpRet));
    if ((it.op == OpStkAdj || it.op == OpCall || it.op == OpJmp ||
         it.op == OpJmpIf) && $urandom_range(0, 9) != 0) begin
      if (it.op == OpCall) it.a = $urandom_range(0, 3);
      else it.a = 32'($signed($urandom_range(0, 8)) - 4);
    end
    if ((it.op == OpInt || it.op == OpLoad) && $urandom_range(0, 2) == 0)
      it.a = 32'($signed($urandom_range(0, 20)) - 10);
    return it;
  endfunction

  // Queues a well-formed sequence: a deep call chain, or a stack filled past
  // its top and then emptied again.
  task automatic plan_sequence();
    instr_t it;
    int n;
    if ($urandom_range(0, 1) == 0) begin
      n = $urandom_range(CallDepth - 4, CallDepth + 3);
      repeat (n) begin
        it = '{OpCall, 32'd0, 16'($urandom)};
        plan_q.push_back(it);
      end
      repeat (n + 1) begin
        it = '{OpRet, 32'd0, 16'd0};
        plan_q.push_back(it);
      end
    end else begin
      repeat (StackDepth + 4) begin
        it = '{OpInt, $urandom, 16'd0};
        plan_q.push_back(it);
      end
      it = '{OpCall, 32'd0, 16'($urandom)};
      plan_q.push_back(it);
      it = '{OpStkAdj, 32'hFFFF_FF00, 16'd0};
      plan_q.push_back(it);
    end
  endtask

  function automatic instr_t next_random();
    instr_t it;
    if (plan_q.size() > 0) begin
      it = plan_q.pop_front();
      if (!reads_written(it)) it = '{OpTrue, 32'd0, 16'd0};
      return it;
    end
    do it = pick_instr(); while (!reads_written(it));
    return it;
  endfunction

  // Offers one transaction and waits until it is taken. The handshake is
  // sampled on the falling edge, where every signal has settled.
  task automatic offer(input instr_t it);
    bit taken;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= it.op;
    operand_a_i <= it.a;
    operand_b_i <= it.b;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes the start address while the block is idle; this also loads the pc.
  task automatic write_entry(input logic [15:0] val);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    entry_q = val;
    pc_q = val;
  endtask

  task automatic run_random(input int n, input bit squeeze);
    instr_t it;
    outcome_t r;
    for (int i = 0; i < n; i++) begin
      if (plan_q.size() == 0 && $urandom_range(0, 99) == 0) plan_sequence();
      if (squeeze && i == n / 3) hold_req = 1'b1;
      // Halfway through, the sender stops until every result is back.
      if (i == n / 2) begin
        in_valid_i <= 1'b0;
        while (pending_q.size() > 0) @(posedge clk_i);
      end
      it = next_random();
      execute(it, r);
      pending_q.push_back(r);
      offer(it);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Result checker and watchdog.
  initial begin
    outcome_t w;
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          w = pending_q.pop_front();
          if (next_pc_o !== w.pc) begin
            $error("next_pc: expected %h, got %h", w.pc, next_pc_o);
            errors++;
          end
          if (top_value_o !== w.top) begin
            $error("top_value: expected %h, got %h", w.top, top_value_o);
            errors++;
          end
          if (done_res_o !== w.done) begin
            $error("done_res: expected %b, got %b", w.done, done_res_o);
            errors++;
          end
          if (fault_o !== w.fault) begin
            $error("fault: expected %0d, got %0d", w.fault, fault_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    instr_t it;
    outcome_t r;
    for (int i = 0; i < StackDepth; i++) begin
      stk[i] = '0;
      wr[i] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run at the reset values with no idling.
    foreach (DirTable[i]) begin
      it = '{DirTable[i].op, DirTable[i].a, DirTable[i].b};
      execute(it, r);
      pending_q.push_back(DirTable[i].chk ? DirTable[i].want : r);
      offer(it);
    end

    write_entry(16'hFFFF);
    send_idle = 36;
    recv_idle = 73;
    run_random(RandPerPhase, 1'b1);

    write_entry(16'($urandom));
    send_idle = 73;
    recv_idle = 36;
    run_random(RandPerPhase, 1'b0);

    write_entry(16'd0);
    send_idle = 0;
    recv_idle = 0;
    run_random(RandPerPhase, 1'b0);

    settle();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
